// ===== hw/rtl/ags_pkg.sv =====
// Package: shared constants, register indexes and types of the angle gain scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ags_pkg;

    localparam int KNOT_COUNT      = 3;
    localparam int BLEND_FRAC_BITS = 16;

    // Quotient bits resolved per divider stage
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (BLEND_FRAC_BITS + DIV_STEP - 1) / DIV_STEP;

    localparam int KNOT_LAST = KNOT_COUNT - 1;
    localparam int KNOT_MID  = (KNOT_COUNT > 2) ? 1 : KNOT_COUNT - 1;

    localparam int KIDX_W = (KNOT_COUNT > 1) ? $clog2(KNOT_COUNT) : 1;

    // Configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FALLBACK = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KNOT0    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KNOT1    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KNOTN    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RATIO    = 3'd5;

    localparam int CFG_DATA_W = 64;

    // Operation codes
    localparam logic [1:0] OP_HOLD    = 2'd0;
    localparam logic [1:0] OP_MOVE    = 2'd1;
    localparam logic [1:0] OP_SUPPORT = 2'd2;

    // Divide by one hundred: (v * RECIP_100) >> RECIP_SHIFT, exact for v below 2^15
    localparam int          RECIP_SHIFT = 21;
    localparam logic [14:0] RECIP_100   = 15'd20972;
    localparam logic [6:0]  RATIO_MAX   = 7'd100;

    typedef logic [47:0] gain_word_t;   // move P,D,I then hold P,D,I

endpackage : ags_pkg
`default_nettype wire

// ===== hw/rtl/ags_if.sv =====
// Interfaces: query channel (angle, operation) and result channel (P, D, I gains).
`timescale 1ns / 1ps
`default_nettype none
interface ags_query_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] joint_angle;
    logic        [1:0] operation;

    modport source (output valid, output joint_angle, output operation, input ready);
    modport sink   (input valid, input joint_angle, input operation, output ready);
endinterface : ags_query_if

interface ags_gain_if;
    logic       valid;
    logic       ready;
    logic [7:0] gain_p;
    logic [7:0] gain_d;
    logic [7:0] gain_i;

    modport source (output valid, output gain_p, output gain_d, output gain_i, input ready);
    modport sink   (input valid, input gain_p, input gain_d, input gain_i, output ready);
endinterface : ags_gain_if
`default_nettype wire

// ===== hw/rtl/angle_gain_scheduler.sv =====
// Top level: angle-scheduled P, D and I gains with smoothstep interpolation between knots.
// Stages: input, select, divider, square, smoothstep, interpolation, blend multiply, output.
// Throughput: one query word per cycle unless the output stalls; the restoring divider
// is cut into DIV_STAGES stages of DIV_STEP quotient bits each and sets the stage depth.
// Stalls hold per stage: an empty stage keeps filling while the output word waits.
// Reset (rst_n low, asynchronous) empties the pipeline and clears the config registers to 0.
`timescale 1ns / 1ps
`default_nettype none
module angle_gain_scheduler
    import ags_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [REG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    ags_query_if.sink                  angle_query,
    ags_gain_if.source                 gain_result
);

    localparam int B   = BLEND_FRAC_BITS;
    localparam int IW  = B + 12;

    // Stage map
    localparam int ST_IN   = 0;
    localparam int ST_SEL  = 1;
    localparam int ST_DIV0 = 2;
    localparam int ST_SQ   = ST_DIV0 + DIV_STAGES;
    localparam int ST_SM   = ST_SQ + 1;
    localparam int ST_INT  = ST_SM + 1;
    localparam int ST_BM   = ST_INT + 1;
    localparam int ST_OUT  = ST_BM + 1;
    localparam int NST     = ST_OUT + 1;

    localparam logic [B:0] ONE = {1'b1, {B{1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        enable_reg;
    logic [23:0] fallback_reg;
    logic [63:0] knot_reg [KNOT_COUNT];
    logic [6:0]  ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            fallback_reg <= '0;
            ratio_reg    <= '0;
            for (int k = 0; k < KNOT_COUNT; k++)
            begin
                knot_reg[k] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ENABLE:   enable_reg   <= wr_data[0];
                REG_FALLBACK: fallback_reg <= wr_data[23:0];
                REG_KNOT0:    knot_reg[0]  <= wr_data;
                REG_KNOT1:    knot_reg[KNOT_MID]  <= wr_data;
                REG_KNOTN:    knot_reg[KNOT_LAST] <= wr_data;
                REG_RATIO:    ratio_reg    <= wr_data[6:0];
                default:      ; // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its word moves on
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || gain_result.ready;
        for (int s = NST - 2; s >= 0; s--)
        begin
            en[s] = !vld_reg[s] || en[s+1];
        end
    end

    assign angle_query.ready = en[ST_IN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[ST_IN])
            begin
                vld_reg[ST_IN] <= angle_query.valid;
            end
            for (int s = 1; s < NST; s++)
            begin
                if (en[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage: register the query word
    // ------------------------------------------------------------------
    logic signed [15:0] angle_reg;
    logic [1:0]         op_in_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            angle_reg <= angle_query.joint_angle;
            op_in_reg <= angle_query.operation;
        end
    end

    // ------------------------------------------------------------------
    // Select stage: clamp, pick the segment and set up the division.
    // Every non-interpolating case sets both ends to the same gains, so the
    // interpolation returns them unchanged.
    // ------------------------------------------------------------------
    logic signed [15:0] knot_ang [KNOT_COUNT];
    gain_word_t         sel_lo_next, sel_hi_next;
    logic [15:0]        sel_num_next, sel_den_next;

    always_comb
    begin
        for (int k = 0; k < KNOT_COUNT; k++)
        begin
            knot_ang[k] = $signed(knot_reg[k][63:48]);
        end
    end

    always_comb
    begin
        logic               found;
        logic signed [16:0] span;
        logic signed [16:0] offs;
        found        = 1'b0;
        span         = '0;
        offs         = '0;
        sel_lo_next  = knot_reg[KNOT_LAST][47:0];
        sel_hi_next  = knot_reg[KNOT_LAST][47:0];
        sel_num_next = '0;
        sel_den_next = 16'd1;
        if (!enable_reg)
        begin
            sel_lo_next = {fallback_reg, fallback_reg};
            sel_hi_next = {fallback_reg, fallback_reg};
        end
        else if (angle_reg <= knot_ang[0])
        begin
            sel_lo_next = knot_reg[0][47:0];
            sel_hi_next = knot_reg[0][47:0];
        end
        else if (angle_reg < knot_ang[KNOT_LAST])
        begin
            for (int k = 1; k < KNOT_COUNT; k++)
            begin
                if (!found && angle_reg <= knot_ang[k])
                begin
                    found = 1'b1;
                    sel_hi_next = knot_reg[k][47:0];
                    if (knot_ang[k] <= knot_ang[k-1])
                    begin
                        sel_lo_next = knot_reg[k][47:0];
                    end
                    else
                    begin
                        span = 17'(knot_ang[k]) - 17'(knot_ang[k-1]);
                        offs = 17'(angle_reg) - 17'(knot_ang[k-1]);
                        sel_lo_next  = knot_reg[k-1][47:0];
                        sel_den_next = span[15:0];
                        sel_num_next = (angle_reg <= knot_ang[k-1]) ? 16'd0 : offs[15:0];
                    end
                end
            end
        end
    end

    gain_word_t  sel_lo_reg, sel_hi_reg;
    logic [15:0] sel_num_reg, sel_den_reg;
    logic [1:0]  sel_op_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SEL])
        begin
            sel_lo_reg  <= sel_lo_next;
            sel_hi_reg  <= sel_hi_next;
            sel_num_reg <= sel_num_next;
            sel_den_reg <= sel_den_next;
            sel_op_reg  <= op_in_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider: x = (num << B) / den with num <= den. The top quotient bit
    // is set only when num equals den; the remaining B bits are resolved
    // DIV_STEP per stage by restoring division.
    // ------------------------------------------------------------------
    logic [16:0] div_rem_reg [DIV_STAGES];
    logic [B:0]  div_q_reg   [DIV_STAGES];
    logic [15:0] div_den_reg [DIV_STAGES];
    gain_word_t  div_lo_reg  [DIV_STAGES];
    gain_word_t  div_hi_reg  [DIV_STAGES];
    logic [1:0]  div_op_reg  [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [16:0] rem_in;
        logic [B:0]  q_in;
        logic [15:0] den_in;
        gain_word_t  lo_in;
        gain_word_t  hi_in;
        logic [1:0]  op_in;
        logic [16:0] rem_next;
        logic [B:0]  q_next;

        if (j == 0) begin : g_first
            always_comb
            begin
                den_in = sel_den_reg;
                lo_in  = sel_lo_reg;
                hi_in  = sel_hi_reg;
                op_in  = sel_op_reg;
                if (sel_num_reg == sel_den_reg)
                begin
                    rem_in = '0;
                    q_in   = {1'b1, {B{1'b0}}};
                end
                else
                begin
                    rem_in = {1'b0, sel_num_reg};
                    q_in   = '0;
                end
            end
        end
        else begin : g_next
            always_comb
            begin
                rem_in = div_rem_reg[j-1];
                q_in   = div_q_reg[j-1];
                den_in = div_den_reg[j-1];
                lo_in  = div_lo_reg[j-1];
                hi_in  = div_hi_reg[j-1];
                op_in  = div_op_reg[j-1];
            end
        end

        always_comb
        begin
            logic [16:0] shifted;
            shifted  = '0;
            rem_next = rem_in;
            q_next   = q_in;
            for (int t = 0; t < DIV_STEP; t++)
            begin
                if (j * DIV_STEP + t < B)
                begin
                    shifted = {rem_next[15:0], 1'b0};
                    if (shifted >= {1'b0, den_in})
                    begin
                        rem_next = shifted - {1'b0, den_in};
                        q_next[B-1-(j*DIV_STEP+t)] = 1'b1;
                    end
                    else
                    begin
                        rem_next = shifted;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_DIV0+j])
            begin
                div_rem_reg[j] <= rem_next;
                div_q_reg[j]   <= q_next;
                div_den_reg[j] <= den_in;
                div_lo_reg[j]  <= lo_in;
                div_hi_reg[j]  <= hi_in;
                div_op_reg[j]  <= op_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Square stage: x2 = x*x >> B, and the smoothstep factor 3 - 2x
    // ------------------------------------------------------------------
    logic [B:0]       x_last;
    logic [2*B+1:0]   sq_prod;
    logic [B:0]       sq_x2_reg;
    logic [B+1:0]     sq_t_reg;
    gain_word_t       sq_lo_reg, sq_hi_reg;
    logic [1:0]       sq_op_reg;

    assign x_last  = div_q_reg[DIV_STAGES-1];
    assign sq_prod = x_last * x_last;

    always_ff @(posedge clk)
    begin
        if (en[ST_SQ])
        begin
            sq_x2_reg <= sq_prod[2*B:B];
            sq_t_reg  <= {ONE, 1'b0} + {1'b0, ONE} - {x_last, 1'b0};
            sq_lo_reg <= div_lo_reg[DIV_STAGES-1];
            sq_hi_reg <= div_hi_reg[DIV_STAGES-1];
            sq_op_reg <= div_op_reg[DIV_STAGES-1];
        end
    end

    // ------------------------------------------------------------------
    // Smoothstep stage: s = x2 * (3 - 2x) >> B, never above one
    // ------------------------------------------------------------------
    logic [2*B+2:0] sm_prod;
    logic [B:0]     sm_s_reg;
    gain_word_t     sm_lo_reg, sm_hi_reg;
    logic [1:0]     sm_op_reg;

    assign sm_prod = sq_x2_reg * sq_t_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SM])
        begin
            sm_s_reg  <= sm_prod[2*B:B];
            sm_lo_reg <= sq_lo_reg;
            sm_hi_reg <= sq_hi_reg;
            sm_op_reg <= sq_op_reg;
        end
    end

    // ------------------------------------------------------------------
    // Interpolation stage: six gains, rounded half up
    // ------------------------------------------------------------------
    gain_word_t int_next;
    gain_word_t int_g_reg;
    logic [1:0] int_op_reg;

    always_comb
    begin
        logic [7:0]          lo_b, hi_b;
        logic signed [IW-1:0] lo_x, prod, tot;
        lo_b = '0;
        hi_b = '0;
        lo_x = '0;
        prod = '0;
        tot  = '0;
        int_next = '0;
        for (int b = 0; b < 6; b++)
        begin
            lo_b = sm_lo_reg[8*b +: 8];
            hi_b = sm_hi_reg[8*b +: 8];
            lo_x = {{(IW-8-B){1'b0}}, lo_b, {B{1'b0}}};
            prod = IW'($signed({1'b0, hi_b}) - $signed({1'b0, lo_b}))
                 * IW'($signed({1'b0, sm_s_reg}));
            tot  = lo_x + prod + IW'(ONE >> 1);
            int_next[8*b +: 8] = tot[B+7:B];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_INT])
        begin
            int_g_reg  <= int_next;
            int_op_reg <= sm_op_reg;
        end
    end

    // ------------------------------------------------------------------
    // Blend multiply stage: |move - hold| * ratio for P and D
    // ------------------------------------------------------------------
    logic [6:0]  ratio_sat;
    logic [7:0]  h_p, h_d, h_i, m_p, m_d, m_i;
    logic [7:0]  dir_p, dir_d, dir_i;
    logic [7:0]  mag_p, mag_d;

    assign ratio_sat = (ratio_reg > RATIO_MAX) ? RATIO_MAX : ratio_reg;
    assign m_p = int_g_reg[47:40];
    assign m_d = int_g_reg[39:32];
    assign m_i = int_g_reg[31:24];
    assign h_p = int_g_reg[23:16];
    assign h_d = int_g_reg[15:8];
    assign h_i = int_g_reg[7:0];
    assign mag_p = (m_p >= h_p) ? m_p - h_p : h_p - m_p;
    assign mag_d = (m_d >= h_d) ? m_d - h_d : h_d - m_d;

    always_comb
    begin
        unique case (int_op_reg)
            OP_MOVE:
            begin
                dir_p = m_p;
                dir_d = m_d;
                dir_i = m_i;
            end
            default:
            begin
                dir_p = h_p;
                dir_d = h_d;
                dir_i = h_i;
            end
        endcase
    end

    logic [14:0] bm_mag_p_reg, bm_mag_d_reg;
    logic        bm_neg_p_reg, bm_neg_d_reg;
    logic [7:0]  bm_p_reg, bm_d_reg, bm_i_reg;
    logic        bm_sup_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_BM])
        begin
            bm_mag_p_reg <= mag_p * ratio_sat;
            bm_mag_d_reg <= mag_d * ratio_sat;
            bm_neg_p_reg <= (m_p < h_p);
            bm_neg_d_reg <= (m_d < h_d);
            bm_sup_reg   <= (int_op_reg == OP_SUPPORT);
            bm_p_reg     <= (int_op_reg == OP_SUPPORT) ? h_p : dir_p;
            bm_d_reg     <= (int_op_reg == OP_SUPPORT) ? h_d : dir_d;
            bm_i_reg     <= (int_op_reg == OP_SUPPORT) ? h_i : dir_i;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: divide by one hundred and, for support, apply toward move
    // ------------------------------------------------------------------
    logic [29:0] q_prod_p, q_prod_d;
    logic [7:0]  q_p, q_d;
    logic [7:0]  out_p_next, out_d_next;

    assign q_prod_p = bm_mag_p_reg * RECIP_100;
    assign q_prod_d = bm_mag_d_reg * RECIP_100;
    assign q_p = q_prod_p[RECIP_SHIFT+7:RECIP_SHIFT];
    assign q_d = q_prod_d[RECIP_SHIFT+7:RECIP_SHIFT];

    always_comb
    begin
        out_p_next = bm_p_reg;
        out_d_next = bm_d_reg;
        if (bm_sup_reg)
        begin
            out_p_next = bm_neg_p_reg ? bm_p_reg - q_p : bm_p_reg + q_p;
            out_d_next = bm_neg_d_reg ? bm_d_reg - q_d : bm_d_reg + q_d;
        end
    end

    logic [7:0] out_p_reg, out_d_reg, out_i_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            out_p_reg <= out_p_next;
            out_d_reg <= out_d_next;
            out_i_reg <= bm_i_reg;
        end
    end

    assign gain_result.valid  = vld_reg[ST_OUT];
    assign gain_result.gain_p = out_p_reg;
    assign gain_result.gain_d = out_d_reg;
    assign gain_result.gain_i = out_i_reg;

`ifndef SYNTHESIS
    // An empty output stage opens the whole pipeline to a new query
    assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[ST_OUT] |-> angle_query.ready)
        else $error("query refused with an empty output stage");

    // The fraction never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_SQ-1] |-> (x_last <= ONE))
        else $error("divider fraction above one");

    // The smoothstep weight never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_SM] |-> (sm_s_reg <= ONE))
        else $error("smoothstep weight above one");
`endif

endmodule : angle_gain_scheduler
`default_nettype wire
